### rtl/core/wpdb_pkg.sv
// Shared types, constants and the softening table for the dab pixel blend.
package wpdb_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned ChanW    = 16;
  localparam int unsigned ContactW = 16;
  localparam int unsigned SfacW    = 18;
  localparam int unsigned NumW     = 29;

  // Mask byte above this value presses the paper
  localparam logic [7:0]  DAB_PRESS_MIN   = 8'd125;
  // Contact below this (0.0001 in Q.16) writes nothing
  localparam logic [15:0] CONTACT_MIN     = 16'd7;
  localparam logic [18:0] HALF_Q16        = 19'd32768;
  // Numerator at which the softening index reaches the last table entry
  localparam logic [NumW-1:0] NUM_SAT     = 29'd376012800;
  // ceil(2^40 / 1275), exact floor for numerators below 2^29
  localparam logic [29:0] RECIP_1275      = 30'd862362062;
  localparam logic [15:0] WET_LIMIT       = 16'd512;
  localparam logic [15:0] CHAN_LIMIT      = 16'hffff;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RED_PAIR   = 3'd0,
    CFG_GREEN_PAIR = 3'd1,
    CFG_BLUE_PAIR  = 3'd2,
    CFG_WETNESS    = 3'd3,
    CFG_STRENGTH   = 3'd4,
    CFG_MODE       = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [31:0] paint_red_pair;
    logic [31:0] paint_green_pair;
    logic [31:0] paint_blue_pair;
    logic [15:0] paint_wetness;
    logic [15:0] strength_code;
    logic [1:0]  mode_bits;
  } cfg_t;

  typedef struct packed {
    logic [ChanW-1:0] red_dense;
    logic [ChanW-1:0] red_wet;
    logic [ChanW-1:0] green_dense;
    logic [ChanW-1:0] green_wet;
    logic [ChanW-1:0] blue_dense;
    logic [ChanW-1:0] blue_wet;
    logic [ChanW-1:0] wetness;
    logic [ChanW-1:0] dither;
  } pix_t;

  typedef struct packed {
    logic                valid;
    logic                hit;
    logic [ContactW-1:0] contact;
    logic [SfacW-1:0]    sfac_paint;
    logic [SfacW-1:0]    sfac_wet;
  } contact_t;

  // round(32768 * exp(-2 - k / 4)) for k = 0..32
  function automatic logic [12:0] soften_lut(input logic [5:0] k);
    logic [12:0] e;
    case (k)
      6'd0:  e = 13'd4435;
      6'd1:  e = 13'd3454;
      6'd2:  e = 13'd2690;
      6'd3:  e = 13'd2095;
      6'd4:  e = 13'd1631;
      6'd5:  e = 13'd1271;
      6'd6:  e = 13'd990;
      6'd7:  e = 13'd771;
      6'd8:  e = 13'd600;
      6'd9:  e = 13'd467;
      6'd10: e = 13'd364;
      6'd11: e = 13'd283;
      6'd12: e = 13'd221;
      6'd13: e = 13'd172;
      6'd14: e = 13'd134;
      6'd15: e = 13'd104;
      6'd16: e = 13'd81;
      6'd17: e = 13'd63;
      6'd18: e = 13'd49;
      6'd19: e = 13'd38;
      6'd20: e = 13'd30;
      6'd21: e = 13'd23;
      6'd22: e = 13'd18;
      6'd23: e = 13'd14;
      6'd24: e = 13'd11;
      6'd25: e = 13'd9;
      6'd26: e = 13'd7;
      6'd27: e = 13'd5;
      6'd28: e = 13'd4;
      6'd29: e = 13'd3;
      6'd30: e = 13'd2;
      6'd31: e = 13'd2;
      default: e = 13'd1;
    endcase
    return e;
  endfunction

endpackage

### rtl/core/wpdb_cfg.sv
// Configuration register file for the dab pixel blend.
module wpdb_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [wpdb_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [31:0]                 cfg_data,
  output wpdb_pkg::cfg_t              cfg
);
  import wpdb_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg         = cfg_r;

  // Decode the write word into its register
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_RED_PAIR:   cfg_nxt.paint_red_pair   = cfg_data;
        CFG_GREEN_PAIR: cfg_nxt.paint_green_pair = cfg_data;
        CFG_BLUE_PAIR:  cfg_nxt.paint_blue_pair  = cfg_data;
        CFG_WETNESS:    cfg_nxt.paint_wetness    = cfg_data[15:0];
        CFG_STRENGTH:   cfg_nxt.strength_code    = cfg_data[15:0];
        CFG_MODE:       cfg_nxt.mode_bits        = cfg_data[1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

### rtl/core/wpdb_contact.sv
// Three-stage contact and strength pipeline: press, divide by 1275, soften.
module wpdb_contact (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [7:0]          dab_level,
  input  logic [15:0]         pen_pressure,
  input  logic [15:0]         absorb_height,
  input  logic [15:0]         absorb_wetness,
  input  wpdb_pkg::cfg_t      cfg,
  output wpdb_pkg::contact_t  res
);
  import wpdb_pkg::*;

  // Stage 1 registers
  logic             v1_r;
  logic             pos1_r;
  logic [NumW-1:0]  n1_r;
  logic [17:0]      s0_1_r;
  logic [17:0]      sq1_r;
  logic [SfacW-1:0] wsf1_r;
  // Stage 2 registers
  logic             v2_r;
  logic             pos2_r;
  logic [18:0]      craw2_r;
  logic [SfacW-1:0] s2_r;
  logic [SfacW-1:0] wsf2_r;
  // Stage 3 registers
  logic                v3_r;
  logic                hit3_r;
  logic [ContactW-1:0] contact3_r;
  logic [SfacW-1:0]    sfp3_r;
  logic [SfacW-1:0]    sfw3_r;

  logic [16:0]        tc;
  logic [17:0]        s0;
  logic [17:0]        sq;
  logic [15:0]        lp;
  logic [13:0]        press;
  logic signed [35:0] num;
  logic [NumW-1:0]    n_sat;
  logic [SfacW-1:0]   wsf;
  logic [58:0]        cprod;
  logic [35:0]        sprod;
  logic [18:0]        dlt;
  logic [5:0]         k;
  logic [12:0]        ea;
  logic [12:0]        eb;
  logic [25:0]        slope;
  logic [12:0]        t;
  logic [15:0]        c_soft;
  logic [15:0]        c_fin;

  // Stage 1: base strength, local pressure, contact numerator
  always_comb begin
    tc = {cfg.strength_code, 1'b0};
    if (tc >= 17'd131070) begin
      s0 = {1'b0, tc} + 18'd2;
    end else if (tc >= 17'd65535) begin
      s0 = {1'b0, tc} + 18'd1;
    end else begin
      s0 = {1'b0, tc};
    end
    sq    = s0 + (cfg.mode_bits[0] ? {2'b0, pen_pressure} : 18'd32768);
    lp    = 16'd49152 + {2'b0, pen_pressure[15:2]};
    press = lp[15:2];
    num   = (dab_level > DAB_PRESS_MIN) ? 36'sd0 + $signed({22'b0, press}) * 36'sd255
                                        : -36'sd16711680;
    num   = num + $signed({3'b0, {1'b0, absorb_height} + {1'b0, absorb_wetness}, 16'b0})
                - 36'sd12582912;
    n_sat = (num >= $signed({7'b0, NUM_SAT})) ? NUM_SAT : num[NumW-1:0];
    wsf   = cfg.mode_bits[1] ? (18'd32768 + {2'b0, lp}) : 18'd65536;
  end

  // Stage 2: reciprocal divide and strength square
  always_comb begin
    cprod = {30'b0, n1_r} * {29'b0, RECIP_1275};
    sprod = {18'b0, s0_1_r} * {18'b0, sq1_r};
  end

  // Stage 3: soften contact above one half by table interpolation
  always_comb begin
    dlt   = craw2_r - HALF_Q16;
    k     = dlt[18:13];
    ea    = soften_lut(k);
    eb    = soften_lut(k + 6'd1);
    slope = {13'b0, ea - eb} * {13'b0, dlt[12:0]};
    t     = (k >= 6'd32) ? soften_lut(6'd32) : (ea - slope[25:13]);
    c_soft = 16'(17'd65536 - {4'b0, t});
    if (!pos2_r) begin
      c_fin = '0;
    end else if (craw2_r > HALF_Q16) begin
      c_fin = c_soft;
    end else begin
      c_fin = craw2_r[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Advance payload every cycle
  always_ff @(posedge clk) begin
    pos1_r <= (num > 36'sd0);
    n1_r   <= n_sat;
    s0_1_r <= s0;
    sq1_r  <= sq;
    wsf1_r <= wsf;

    pos2_r  <= pos1_r;
    craw2_r <= cprod[58:40];
    s2_r    <= sprod[34:17];
    wsf2_r  <= wsf1_r;

    hit3_r     <= (c_fin >= CONTACT_MIN);
    contact3_r <= c_fin;
    sfp3_r     <= s2_r;
    sfw3_r     <= wsf2_r;
  end

  assign res = '{valid: v3_r, hit: hit3_r, contact: contact3_r,
                 sfac_paint: sfp3_r, sfac_wet: sfw3_r};

endmodule

### rtl/core/wpdb_lane.sv
// Two-stage blend of one channel toward its target colour, dithered and clamped.
module wpdb_lane (
  input  logic                            clk,
  input  logic [wpdb_pkg::ChanW-1:0]      paint,
  input  logic [wpdb_pkg::SfacW-1:0]      sfac,
  input  logic [wpdb_pkg::ContactW-1:0]   contact,
  input  logic                            hit,
  input  logic [wpdb_pkg::ChanW-1:0]      pix,
  input  logic [wpdb_pkg::ChanW-1:0]      dither,
  input  logic [wpdb_pkg::ChanW-1:0]      limit,
  output logic [wpdb_pkg::ChanW-1:0]      result
);
  import wpdb_pkg::*;

  logic [31:0]      pc_r;
  logic [32:0]      vc_r;
  logic [SfacW-1:0] sfac_r;
  logic [ChanW-1:0] pix_r;
  logic [ChanW-1:0] dith_r;
  logic [ChanW-1:0] lim_r;
  logic             hit_r;
  logic [ChanW-1:0] res_r;

  logic [16:0] keep;
  logic [51:0] lo_part;
  logic [33:0] hi_prod;
  logic [51:0] hi_part;
  logic [51:0] tot;
  logic [19:0] whole;
  logic [ChanW-1:0] res_nxt;

  assign keep = 17'd65536 - {1'b0, contact};

  // Stage A: paint times contact, pixel times remainder
  always_ff @(posedge clk) begin
    pc_r   <= {16'b0, paint} * {16'b0, contact};
    vc_r   <= {17'b0, pix} * {16'b0, keep};
    sfac_r <= sfac;
    pix_r  <= pix;
    dith_r <= dither;
    lim_r  <= limit;
    hit_r  <= hit;
  end

  // Stage B: scale by strength split into low half and integer part, then floor
  always_comb begin
    lo_part = {20'b0, pc_r} * {36'b0, sfac_r[15:0]};
    hi_prod = {2'b0, pc_r} * {32'b0, sfac_r[17:16]};
    hi_part = {2'b0, hi_prod, 16'b0};
    tot     = lo_part + hi_part + {3'b0, vc_r, 16'b0} + {20'b0, dith_r, 16'b0};
    whole   = tot[51:32];
    if (!hit_r) begin
      res_nxt = pix_r;
    end else if (whole > {4'b0, lim_r}) begin
      res_nxt = lim_r;
    end else begin
      res_nxt = whole[15:0];
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign result = res_r;

endmodule

### rtl/core/wet_paint_dab_pixel_blend.sv
// Wet-paint dab pixel blend: one brush-dab pixel per clock, fully pipelined.
//
// Input channel: drive start high with the pixel words on the in_ ports; a word
// is taken at every clock edge with start high, since busy is held low and a
// new pixel may enter each cycle.
// Result channel: out_valid strobes for one cycle with the blended channels,
// wetness and pixel_written; the receiver must take it in that cycle.
// From accept to strobe a pixel passes three contact stages (press and
// numerator, reciprocal divide by 1275 with strength square, table softening)
// and two per-channel blend stages (products, scaled sum with clamp). One
// pixel per cycle sustained.
// Configuration: cfg_valid/cfg_ready write channel, cfg_ready always high;
// write only while no pixels are in flight.
// Reset clears the configuration registers and all valid bits; payload
// registers are left alone.
module wet_paint_dab_pixel_blend (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  in_dab_level,
  input  logic [15:0] in_pen_pressure,
  input  logic [15:0] in_absorb_height,
  input  logic [15:0] in_absorb_wetness,
  input  logic [15:0] in_red_dense,
  input  logic [15:0] in_red_wet,
  input  logic [15:0] in_green_dense,
  input  logic [15:0] in_green_wet,
  input  logic [15:0] in_blue_dense,
  input  logic [15:0] in_blue_wet,
  input  logic [15:0] in_pixel_wetness,
  input  logic [15:0] in_dither,
  output logic        out_valid,
  output logic [15:0] out_new_red_dense,
  output logic [15:0] out_new_red_wet,
  output logic [15:0] out_new_green_dense,
  output logic [15:0] out_new_green_wet,
  output logic [15:0] out_new_blue_dense,
  output logic [15:0] out_new_blue_wet,
  output logic [15:0] out_new_wetness,
  output logic        out_pixel_written,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [wpdb_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [31:0] cfg_data
);
  import wpdb_pkg::*;

  cfg_t     cfg;
  contact_t cres;
  pix_t     pix_in;
  pix_t     pix_d_r [3];
  logic     v4_r;
  logic     v5_r;
  logic     hit4_r;
  logic     hit5_r;
  logic [ChanW-1:0] wet_lim;

  assign busy = 1'b0;

  wpdb_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  wpdb_contact u_contact (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (start),
    .dab_level      (in_dab_level),
    .pen_pressure   (in_pen_pressure),
    .absorb_height  (in_absorb_height),
    .absorb_wetness (in_absorb_wetness),
    .cfg            (cfg),
    .res            (cres)
  );

  // Hold pixel words alongside the contact stages
  assign pix_in = '{red_dense: in_red_dense, red_wet: in_red_wet,
                    green_dense: in_green_dense, green_wet: in_green_wet,
                    blue_dense: in_blue_dense, blue_wet: in_blue_wet,
                    wetness: in_pixel_wetness, dither: in_dither};

  always_ff @(posedge clk) begin
    pix_d_r[0] <= pix_in;
    pix_d_r[1] <= pix_d_r[0];
    pix_d_r[2] <= pix_d_r[1];
    hit4_r     <= cres.hit;
    hit5_r     <= hit4_r;
  end

  // Advance valid through the blend stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v4_r <= cres.valid;
      v5_r <= v4_r;
    end
  end

  assign wet_lim = cfg.mode_bits[1] ? WET_LIMIT : CHAN_LIMIT;

  wpdb_lane u_red_dense (
    .clk (clk), .paint (cfg.paint_red_pair[15:0]), .sfac (cres.sfac_paint),
    .contact (cres.contact), .hit (cres.hit), .pix (pix_d_r[2].red_dense),
    .dither (pix_d_r[2].dither), .limit (CHAN_LIMIT), .result (out_new_red_dense)
  );
  wpdb_lane u_red_wet (
    .clk (clk), .paint (cfg.paint_red_pair[31:16]), .sfac (cres.sfac_paint),
    .contact (cres.contact), .hit (cres.hit), .pix (pix_d_r[2].red_wet),
    .dither (pix_d_r[2].dither), .limit (CHAN_LIMIT), .result (out_new_red_wet)
  );
  wpdb_lane u_green_dense (
    .clk (clk), .paint (cfg.paint_green_pair[15:0]), .sfac (cres.sfac_paint),
    .contact (cres.contact), .hit (cres.hit), .pix (pix_d_r[2].green_dense),
    .dither (pix_d_r[2].dither), .limit (CHAN_LIMIT), .result (out_new_green_dense)
  );
  wpdb_lane u_green_wet (
    .clk (clk), .paint (cfg.paint_green_pair[31:16]), .sfac (cres.sfac_paint),
    .contact (cres.contact), .hit (cres.hit), .pix (pix_d_r[2].green_wet),
    .dither (pix_d_r[2].dither), .limit (CHAN_LIMIT), .result (out_new_green_wet)
  );
  wpdb_lane u_blue_dense (
    .clk (clk), .paint (cfg.paint_blue_pair[15:0]), .sfac (cres.sfac_paint),
    .contact (cres.contact), .hit (cres.hit), .pix (pix_d_r[2].blue_dense),
    .dither (pix_d_r[2].dither), .limit (CHAN_LIMIT), .result (out_new_blue_dense)
  );
  wpdb_lane u_blue_wet (
    .clk (clk), .paint (cfg.paint_blue_pair[31:16]), .sfac (cres.sfac_paint),
    .contact (cres.contact), .hit (cres.hit), .pix (pix_d_r[2].blue_wet),
    .dither (pix_d_r[2].dither), .limit (CHAN_LIMIT), .result (out_new_blue_wet)
  );
  wpdb_lane u_wetness (
    .clk (clk), .paint (cfg.paint_wetness), .sfac (cres.sfac_wet),
    .contact (cres.contact), .hit (cres.hit), .pix (pix_d_r[2].wetness),
    .dither (pix_d_r[2].dither), .limit (wet_lim), .result (out_new_wetness)
  );

  assign out_valid         = v5_r;
  assign out_pixel_written = hit5_r;

endmodule
